### rtl/pom_pkg.sv
package pom_pkg;

  // Field widths of the sample and result beats.
  localparam int unsigned AC_W    = 12;
  localparam int unsigned DC_W    = 12;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned SPO2_W  = 7;

  // Datapath widths: products, SpO2 dividend, divider remainder and shift register.
  localparam int unsigned PROD_W = AC_W + DC_W;
  localparam int unsigned DVD_W  = 33;
  localparam int unsigned REM_W  = 26;
  localparam int unsigned Q_W    = 16;
  localparam int unsigned STEP_W = 5;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd30000;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 16'hFFFF;

  localparam logic [STEP_W-1:0] SPO2_STEPS  = 5'd7;
  localparam logic [STEP_W-1:0] PULSE_STEPS = 5'd16;

  // Coefficients of the piecewise SpO2 line, all in units of the denominator.
  localparam logic [DVD_W-1:0] K_LO_NUM = 33'd5;
  localparam logic [DVD_W-1:0] K_LO_DEN = 33'd2;
  localparam logic [DVD_W-1:0] K_MID_A  = 33'd110;
  localparam logic [DVD_W-1:0] K_MID_B  = 33'd25;
  localparam logic [DVD_W-1:0] K_HI_A   = 33'd354;
  localparam logic [DVD_W-1:0] K_HI_B   = 33'd100;
  localparam logic [REM_W-1:0] K_HI_DIV = 26'd3;

  typedef struct packed {
    logic accept;
    logic load_spo2;
    logic step;
    logic load_pulse;
    logic load_out;
  } pom_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_last;
    logic out_free;
  } pom_sts_t;

endpackage

### rtl/pulse_oximeter_period_measure.sv
// Pulse period and SpO2 measurement.
// Samples arrive on the in_ channel (red/infrared AC and DC), one beat per
// accepted sample. Ordinary samples only update the peak trackers and do not
// raise in_stall, so the input stays ready for the next sample.
// The sample that ends a period (red AC turning positive in the low phase)
// starts the result computation: the two ratio products are formed, the SpO2
// dividend is selected, the shared divider computes the 7-bit SpO2 quotient, is
// reloaded and computes the 16-bit pulse rate, and the output register is
// loaded. in_stall stays high from the acceptance of that sample until the
// output register is loaded. The divider produces one quotient bit per cycle.
// A result waiting in the output register does not stop sample intake; only
// when a second result finishes while the first is still stalled does the
// block hold in_stall until out_stall drops.
// The cfg_ channel writes pulse_scale and is always ready. Synchronous reset
// sets pulse_scale to 30000, clears the trackers and the sample count, and
// drops out_valid.
module pulse_oximeter_period_measure
  import pom_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [AC_W-1:0]    in_red_ac,
  input  logic signed [AC_W-1:0]    in_ir_ac,
  input  logic        [DC_W-1:0]    in_red_dc,
  input  logic        [DC_W-1:0]    in_ir_dc,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic        [SPO2_W-1:0]  out_spo2_percent,
  output logic        [CNT_W-1:0]   out_pulse_rate,
  output logic                      out_ratio_invalid,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [SCALE_W-1:0] cfg_data
);

  pom_cmd_t cmd;
  pom_sts_t sts;

  assign cfg_ready = 1'b1;

  pom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pom_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .red_ac            (in_red_ac),
    .ir_ac             (in_ir_ac),
    .red_dc            (in_red_dc),
    .ir_dc             (in_ir_dc),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_spo2_percent  (out_spo2_percent),
    .out_pulse_rate    (out_pulse_rate),
    .out_ratio_invalid (out_ratio_invalid)
  );

  a_spo2_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_spo2_percent <= SPO2_W'(100)))
    else $error("SpO2 result above 100 percent");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ratio_invalid) |-> (out_spo2_percent == '0))
    else $error("invalid ratio with nonzero SpO2");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat appeared without a computation");

endmodule

### rtl/pom_ctrl.sv
module pom_ctrl
  import pom_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pom_sts_t sts,
  output pom_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL   = 7'b0000010,
    ST_LOADS = 7'b0000100,
    ST_DIVS  = 7'b0001000,
    ST_LOADP = 7'b0010000,
    ST_DIVP  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.emit) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_LOADS;
      end
      ST_LOADS: begin
        cmd.load_spo2 = 1'b1;
        state_nxt     = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_LOADP;
        end
      end
      ST_LOADP: begin
        cmd.load_pulse = 1'b1;
        state_nxt      = ST_DIVP;
      end
      ST_DIVP: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold the finished result until the output register can take it.
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/pom_datapath.sv
module pom_datapath
  import pom_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  pom_cmd_t                 cmd,
  output pom_sts_t                 sts,
  input  logic signed [AC_W-1:0]   red_ac,
  input  logic signed [AC_W-1:0]   ir_ac,
  input  logic        [DC_W-1:0]   red_dc,
  input  logic        [DC_W-1:0]   ir_dc,
  input  logic                     cfg_we,
  input  logic        [SCALE_W-1:0] cfg_data,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic        [SPO2_W-1:0] out_spo2_percent,
  output logic        [CNT_W-1:0]  out_pulse_rate,
  output logic                     out_ratio_invalid
);

  logic [SCALE_W-1:0] scale_r;

  // Peak tracker state.
  logic                   low_r, low_nxt;
  logic signed [AC_W-1:0] red_max_r, red_max_nxt;
  logic signed [AC_W-1:0] red_min_r, red_min_nxt;
  logic signed [AC_W-1:0] ir_max_r, ir_max_nxt;
  logic signed [AC_W-1:0] ir_min_r, ir_min_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   emit;

  // Snapshot of one finished period.
  logic [AC_W-1:0]  ptp_red_r, ptp_ir_r;
  logic [DC_W-1:0]  rdc_r, idc_r;
  logic [CNT_W-1:0] pcount_r;
  logic [PROD_W-1:0] num_r, den_r;

  // Shared restoring divider.
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [Q_W-1:0]    dvd_r, q_r;
  logic [REM_W-1:0]  dsr_r;
  logic [STEP_W-1:0] step_r;
  logic [REM_W:0]    rem_sh, rem_diff;
  logic              q_bit;

  // SpO2 dividend and divisor selection.
  logic [DVD_W-1:0] num_x, den_x, spo2_n;
  logic [REM_W-1:0] spo2_d;
  logic             den_zero, below_lo, below_one, above_hi;

  logic              inv_r;
  logic [SPO2_W-1:0] spo2_r;
  logic              out_valid_r;
  logic [SPO2_W-1:0] out_spo2_r;
  logic [CNT_W-1:0]  out_pulse_r;
  logic              out_inv_r;

  always_comb begin
    low_nxt     = low_r;
    red_max_nxt = red_max_r;
    red_min_nxt = red_min_r;
    ir_max_nxt  = ir_max_r;
    ir_min_nxt  = ir_min_r;
    emit        = 1'b0;
    if (!low_r) begin
      if (red_ac > red_max_r) red_max_nxt = red_ac;
      if (ir_ac > ir_max_r) ir_max_nxt = ir_ac;
      if (red_ac < 0) low_nxt = 1'b1;
    end else begin
      if (red_ac < red_min_r) red_min_nxt = red_ac;
      if (ir_ac < ir_min_r) ir_min_nxt = ir_ac;
      if (red_ac > 0) begin
        low_nxt = 1'b0;
        emit    = 1'b1;
      end
    end
    cnt_nxt = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  end

  assign sts.emit = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RESET;
      low_r     <= 1'b0;
      red_max_r <= '0;
      red_min_r <= '0;
      ir_max_r  <= '0;
      ir_min_r  <= '0;
      cnt_r     <= '0;
    end else begin
      if (cfg_we) begin
        scale_r <= cfg_data;
      end
      if (cmd.accept) begin
        low_r <= low_nxt;
        if (emit) begin
          red_max_r <= '0;
          red_min_r <= '0;
          ir_max_r  <= '0;
          ir_min_r  <= '0;
          cnt_r     <= '0;
        end else begin
          red_max_r <= red_max_nxt;
          red_min_r <= red_min_nxt;
          ir_max_r  <= ir_max_nxt;
          ir_min_r  <= ir_min_nxt;
          cnt_r     <= cnt_nxt;
        end
      end
    end
  end

  // The maximum never drops below zero and the minimum never rises above it,
  // so the peak-to-peak swing always fits the unsigned field width.
  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      ptp_red_r <= red_max_nxt - red_min_nxt;
      ptp_ir_r  <= ir_max_nxt - ir_min_nxt;
      rdc_r     <= red_dc;
      idc_r     <= ir_dc;
      pcount_r  <= cnt_nxt;
    end
    num_r <= ptp_red_r * idc_r;
    den_r <= ptp_ir_r * rdc_r;
  end

  always_comb begin
    num_x     = {{(DVD_W-PROD_W){1'b0}}, num_r};
    den_x     = {{(DVD_W-PROD_W){1'b0}}, den_r};
    den_zero  = (den_r == '0);
    below_lo  = (K_LO_NUM * num_x) < (K_LO_DEN * den_x);
    below_one = (num_r < den_r);
    above_hi  = (K_HI_A * den_x) <= (K_HI_B * num_x);
    spo2_n    = '0;
    spo2_d    = {{(REM_W-PROD_W){1'b0}}, den_r};
    if (den_zero || below_lo) begin
      spo2_n = '0;
    end else if (below_one) begin
      spo2_n = K_MID_A * den_x - K_MID_B * num_x;
    end else if (above_hi) begin
      spo2_n = '0;
    end else begin
      spo2_n = K_HI_A * den_x - K_HI_B * num_x;
      spo2_d = K_HI_DIV * {{(REM_W-PROD_W){1'b0}}, den_r};
    end
  end

  // One quotient bit per cycle. The SpO2 quotient stays below 128, so the
  // upper dividend bits start out as a remainder smaller than the divisor.
  always_comb begin
    rem_sh   = {rem_r, dvd_r[Q_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    q_bit    = (rem_sh >= {1'b0, dsr_r});
    rem_nxt  = q_bit ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
  end

  assign sts.div_last = (step_r == STEP_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load_spo2) begin
      rem_r <= spo2_n[DVD_W-1:SPO2_W];
      dvd_r <= {spo2_n[SPO2_W-1:0], {(Q_W-SPO2_W){1'b0}}};
      dsr_r <= spo2_d;
      inv_r <= den_zero;
    end else if (cmd.load_pulse) begin
      rem_r  <= '0;
      dvd_r  <= scale_r;
      dsr_r  <= {{(REM_W-CNT_W){1'b0}}, pcount_r};
      spo2_r <= inv_r ? '0 : q_r[SPO2_W-1:0];
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[Q_W-2:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load_spo2) begin
      step_r <= SPO2_STEPS;
    end else if (cmd.load_pulse) begin
      step_r <= PULSE_STEPS;
    end else if (cmd.step) begin
      step_r <= step_r - 1'b1;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_spo2_r  <= spo2_r;
      out_pulse_r <= q_r;
      out_inv_r   <= inv_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_spo2_percent  = out_spo2_r;
  assign out_pulse_rate    = out_pulse_r;
  assign out_ratio_invalid = out_inv_r;

endmodule

### sim/tb_top.sv
module tb_top;
  import pom_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_500_000;

  typedef enum logic {PEAK_HIGH, PEAK_LOW} peak_phase_t;

  typedef struct packed {
    logic [SPO2_W-1:0] spo2_percent;
    logic [CNT_W-1:0]  pulse_rate;
    logic              ratio_invalid;
  } vitals_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic signed [AC_W-1:0] in_red_ac = '0;
  logic signed [AC_W-1:0] in_ir_ac = '0;
  logic [DC_W-1:0]     in_red_dc = '0;
  logic [DC_W-1:0]     in_ir_dc = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SPO2_W-1:0]   out_spo2_percent;
  logic [CNT_W-1:0]    out_pulse_rate;
  logic                out_ratio_invalid;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SCALE_W-1:0]  cfg_data = '0;

  // Shadow of the block's tracker state and its one register.
  logic [SCALE_W-1:0] scale_model = SCALE_RESET;
  peak_phase_t        phase_model = PEAK_HIGH;
  int                 red_hi = 0;
  int                 red_lo = 0;
  int                 ir_hi = 0;
  int                 ir_lo = 0;
  int                 period_count = 0;

  vitals_t vitals_queue[$];

  int send_idle_pct = 0;
  int out_stall_pct = 0;
  int failures = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int invalid_seen = 0;
  int nonzero_spo2_seen = 0;
  int cycle_count = 0;

  pulse_oximeter_period_measure u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red_ac         (in_red_ac),
    .in_ir_ac          (in_ir_ac),
    .in_red_dc         (in_red_dc),
    .in_ir_dc          (in_ir_dc),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_spo2_percent  (out_spo2_percent),
    .out_pulse_rate    (out_pulse_rate),
    .out_ratio_invalid (out_ratio_invalid),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               vitals_queue.size());
      $display("pulse_oximeter_period_measure regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Piecewise SpO2 line evaluated on the exact ratio num/den, truncated toward zero.
  function automatic int spo2_of_ratio(input longint unsigned num, input longint unsigned den);
    if (5 * num < 2 * den) return 0;
    if (num < den) return int'((110 * den - 25 * num) / den);
    if (354 * den <= 100 * num) return 0;
    return int'((354 * den - 100 * num) / (3 * den));
  endfunction

  function automatic bit track_sample(input int rac, input int iac, input int rdc,
                                      input int idc, output vitals_t vitals);
    longint unsigned num;
    longint unsigned den;
    bit emit;
    emit = 1'b0;
    vitals = '0;
    if (phase_model == PEAK_HIGH) begin
      if (rac > red_hi) red_hi = rac;
      if (iac > ir_hi) ir_hi = iac;
      if (rac < 0) phase_model = PEAK_LOW;
    end else begin
      if (rac < red_lo) red_lo = rac;
      if (iac < ir_lo) ir_lo = iac;
      if (rac > 0) begin
        phase_model = PEAK_HIGH;
        emit = 1'b1;
      end
    end
    if (period_count < int'(CNT_MAX)) period_count++;
    if (emit) begin
      num = longint'(red_hi - red_lo) * longint'(idc);
      den = longint'(ir_hi - ir_lo) * longint'(rdc);
      vitals.pulse_rate    = CNT_W'(int'(scale_model) / period_count);
      vitals.ratio_invalid = (den == 0);
      vitals.spo2_percent  = (den == 0) ? '0 : SPO2_W'(spo2_of_ratio(num, den));
      period_count = 0;
      red_hi = 0;
      red_lo = 0;
      ir_hi  = 0;
      ir_lo  = 0;
    end
    return emit;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken,
  // with in_valid still high so back-to-back samples need no dead cycle.
  task automatic send_sample(input int red_ac, input int ir_ac, input int red_dc,
                             input int ir_dc);
    vitals_t vitals;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_red_ac <= red_ac[AC_W-1:0];
    in_ir_ac  <= ir_ac[AC_W-1:0];
    in_red_dc <= red_dc[DC_W-1:0];
    in_ir_dc  <= ir_dc[DC_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    if (track_sample(red_ac, ir_ac, red_dc, ir_dc, vitals)) vitals_queue.push_back(vitals);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (vitals_queue.size() != 0);
  endtask

  task automatic write_pulse_scale(input logic [SCALE_W-1:0] value);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    scale_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    vitals_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (vitals_queue.size() == 0) begin
        $error("result with nothing expected: spo2_percent %0d pulse_rate %0d invalid %0b",
               out_spo2_percent, out_pulse_rate, out_ratio_invalid);
        failures++;
      end else begin
        want = vitals_queue.pop_front();
        results_checked++;
        if (want.ratio_invalid) invalid_seen++;
        if (want.spo2_percent != 0) nonzero_spo2_seen++;
        if (out_spo2_percent !== want.spo2_percent) begin
          $error("spo2_percent: expected %0d, actual %0d", want.spo2_percent,
                 out_spo2_percent);
          failures++;
        end
        if (out_pulse_rate !== want.pulse_rate) begin
          $error("pulse_rate: expected %0d, actual %0d", want.pulse_rate, out_pulse_rate);
          failures++;
        end
        if (out_ratio_invalid !== want.ratio_invalid) begin
          $error("ratio_invalid: expected %0b, actual %0b", want.ratio_invalid,
                 out_ratio_invalid);
          failures++;
        end
      end
    end
  end

  // Mostly well-formed pulse cycles (rise, fall, trough, rise again) with random
  // amplitudes and DC levels, mixed with unconstrained samples.
  task automatic send_random_periods(input int n_samples);
    int sent;
    int ar;
    int ai;
    int n_high;
    int n_low;
    int rdc;
    int idc;
    sent = 0;
    while (sent < n_samples) begin
      if ($urandom_range(4) == 0) begin
        send_sample(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                    $urandom_range(4095), $urandom_range(4095));
        sent++;
      end else begin
        ar     = $urandom_range(1, 2047);
        ai     = $urandom_range(0, 2047);
        n_high = $urandom_range(0, 5);
        n_low  = $urandom_range(0, 4);
        repeat (n_high) send_sample($urandom_range(0, ar), $urandom_range(0, ai),
                                    $urandom_range(4095), $urandom_range(4095));
        send_sample(-int'($urandom_range(1, ar + 1)), -int'($urandom_range(0, ai + 1)),
                    $urandom_range(4095), $urandom_range(4095));
        repeat (n_low) send_sample(-int'($urandom_range(0, ar + 1)),
                                   -int'($urandom_range(0, ai + 1)),
                                   $urandom_range(4095), $urandom_range(4095));
        rdc = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
        idc = ($urandom_range(19) == 0) ? 0 : $urandom_range(4095);
        send_sample($urandom_range(1, ar), $urandom_range(0, ai), rdc, idc);
        sent += n_high + n_low + 2;
      end
    end
  endtask

  task automatic test_directed_edges();
    send_idle_pct = 0;
    out_stall_pct = 0;
    // Full-scale swing on both channels; a zero red AC holds the phase either way.
    send_sample(0, 0, 0, 0);
    send_sample(2047, 2047, 4095, 4095);
    send_sample(-2048, -2048, 0, 0);
    send_sample(0, 5, 0, 0);
    send_sample(-2048, -2048, 0, 0);
    send_sample(1, 0, 4095, 4095);
    // Red DC of zero leaves the ratio undefined.
    send_sample(100, 50, 1000, 1000);
    send_sample(-100, -50, 1000, 1000);
    send_sample(7, 3, 0, 4095);
    // Infrared goes negative only in the high phase and at the phase switch, so its peak-to-peak is zero.
    send_sample(100, -5, 1000, 1000);
    send_sample(-1, -3, 1000, 1000);
    send_sample(2047, 0, 1000, 1000);
    // Ratio exactly 0.4, then just under it.
    send_sample(100, 250, 1000, 1000);
    send_sample(-100, -250, 1000, 1000);
    send_sample(5, 0, 1000, 1000);
    send_sample(99, 250, 1000, 1000);
    send_sample(-99, -250, 1000, 1000);
    send_sample(5, 0, 1000, 1000);
    // Ratio exactly 3.54 clamps to zero; 3.5 is just below it.
    send_sample(177, 50, 1000, 1000);
    send_sample(-177, -50, 1000, 1000);
    send_sample(1, 0, 1000, 1000);
    send_sample(175, 50, 1000, 1000);
    send_sample(-175, -50, 1000, 1000);
    send_sample(1, 0, 1000, 1000);
  endtask

  task automatic test_full_rate();
    write_pulse_scale(16'd1);
    send_idle_pct = 0;
    out_stall_pct = 0;
    send_random_periods(130);
  endtask

  task automatic test_sender_gaps();
    write_pulse_scale(16'd0);
    send_idle_pct = 77;
    out_stall_pct = 0;
    send_random_periods(140);
  endtask

  task automatic test_receiver_stalls();
    write_pulse_scale(SCALE_W'($urandom_range(2, 65534)));
    send_idle_pct = 0;
    out_stall_pct = 77;
    send_random_periods(70);
    wait_results_drained();
    send_random_periods(70);
  endtask

  task automatic test_both_idle();
    write_pulse_scale(16'd30000);
    send_idle_pct = 17;
    out_stall_pct = 17;
    send_random_periods(140);
  endtask

  initial begin
    int drain_wait;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_full_rate();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    in_valid <= 1'b0;
    drain_wait = 0;
    do begin
      @(negedge clk);
      drain_wait++;
    end while (vitals_queue.size() != 0 && drain_wait < 5000);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (vitals_queue.size() != 0) begin
      $error("%0d expected results never arrived", vitals_queue.size());
      failures += vitals_queue.size();
    end

    $display("Sent %0d samples and checked %0d results (%0d invalid ratios, %0d nonzero SpO2).",
             samples_sent, results_checked, invalid_seen, nonzero_spo2_seen);
    $display("Scales 0, 1, 30000 and random; ratio edges; all idle mixes.");
    if (failures == 0) begin
      $display("pulse_oximeter_period_measure regression: pass");
    end else begin
      $display("pulse_oximeter_period_measure regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pom_pkg.sv
rtl/pom_ctrl.sv
rtl/pom_datapath.sv
rtl/pulse_oximeter_period_measure.sv
sim/tb_top.sv
